/* src/pac_pkg.sv */
package pac_pkg;

   // table geometry
   localparam int SET_BITS    = 10;
   localparam int WAYS        = 4;
   localparam int THREADS     = 8;
   localparam int COUNT_WIDTH = 32;

   localparam int WAY_BITS      = $clog2(WAYS);
   localparam int THREAD_BITS   = $clog2(THREADS);
   localparam int ENTRY_BITS    = SET_BITS + WAY_BITS;
   localparam int CNT_ADDR_BITS = ENTRY_BITS + THREAD_BITS;
   localparam int SETS          = 1 << SET_BITS;
   localparam int CNT_DEPTH     = 1 << CNT_ADDR_BITS;

   // field widths
   localparam int ADDR_WIDTH   = 48;
   localparam int TAG_WIDTH    = 48;
   localparam int THREAD_WIDTH = 3;
   localparam int INDEX_WIDTH  = 12;
   localparam int SLOT_WIDTH   = 12;
   localparam int RCOUNT_WIDTH = 32;
   localparam int PAGES_WIDTH  = 13;
   localparam int FAIL_WIDTH   = 32;
   localparam int PN_WIDTH     = 32;
   localparam int SHIFT_WIDTH  = 6;
   localparam int ROW_WIDTH    = WAYS * TAG_WIDTH;

   localparam logic [PN_WIDTH-1:0]    HASH_MULT   = 32'h9e37_0001;
   localparam logic [SHIFT_WIDTH-1:0] SHIFT_RESET = 6'd12;
   localparam logic [PAGES_WIDTH-1:0] PAGES_MAX   = '1;

   // register map
   localparam int CSR_ADDR_BITS  = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam logic CSR_PAGE_SHIFT = 1'b0;

   localparam logic MODE_ACCESS = 1'b0;
   localparam logic MODE_READ   = 1'b1;

   typedef enum logic [1:0] {
      STATUS_HIT   = 2'd0,
      STATUS_ALLOC = 2'd1,
      STATUS_DROP  = 2'd2,
      STATUS_READ  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_TAG,
      ST_MATCH,
      ST_COUNT
   } state_type;

   typedef logic [WAYS-1:0][TAG_WIDTH-1:0] row_type;

   typedef struct packed {
      logic                hit;
      logic                free;
      logic [WAY_BITS-1:0] way;
   } match_type;

endpackage

/* src/pac_ram.sv */
module pac_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/pac_match.sv */
module pac_match import pac_pkg::*; (
   input  row_type                row,
   input  logic [TAG_WIDTH-1:0]   page_base,
   output match_type              result
);

   logic                free_found;
   logic [WAY_BITS-1:0] free_way;

   // first way holding the page wins; else the first empty way
   always_comb begin
      result     = '0;
      free_found = 1'b0;
      free_way   = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (!result.hit && row[w] == page_base) begin
            result.hit = 1'b1;
            result.way = WAY_BITS'(w);
         end
         if (!free_found && row[w] == '0) begin
            free_found = 1'b1;
            free_way   = WAY_BITS'(w);
         end
      end
      result.free = free_found;
      if (!result.hit) begin
         result.way = free_way;
      end
   end

endmodule

/* src/page_access_profile_table.sv */
// Per-page, per-thread access counter in a 4-way set-associative table of
// 4096 entries. After reset the block sweeps both memories clear with busy
// high; configuration writes are taken during the sweep. Afterwards each
// command raised on start while busy is low steps through ST_HASH (set
// index registered from the hash product), ST_TAG (tag memory read),
// ST_MATCH (way match) and ST_COUNT (count memory read-modify-write);
// the result strobe rsp_valid rises as the block returns to idle, and start
// is taken again in that same cycle. Results are shown for exactly one cycle
// and cannot be stalled, so the receiver must take every beat as it comes.
module page_access_profile_table import pac_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      start,
   output logic                      busy,
   input  logic                      req_mode,
   input  logic [ADDR_WIDTH-1:0]     req_address,
   input  logic [THREAD_WIDTH-1:0]   req_thread,
   input  logic [INDEX_WIDTH-1:0]    req_read_index,

   output logic                      rsp_valid,
   output logic [1:0]                rsp_status,
   output logic [SLOT_WIDTH-1:0]     rsp_entry_slot,
   output logic [TAG_WIDTH-1:0]      rsp_page_tag,
   output logic [RCOUNT_WIDTH-1:0]   rsp_access_count,
   output logic [PAGES_WIDTH-1:0]    rsp_pages_in_use,
   output logic [FAIL_WIDTH-1:0]     rsp_fail_count,

   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_BITS-1:0]  paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready
);

   state_type                 state_ff, state_in;
   logic [SHIFT_WIDTH-1:0]    shift_ff, shift_in;
   logic [CNT_ADDR_BITS-1:0]  clr_ff, clr_in;
   logic [PAGES_WIDTH-1:0]    pages_ff, pages_in;
   logic [FAIL_WIDTH-1:0]     fail_ff, fail_in;

   logic                      mode_ff, mode_in;
   logic [THREAD_BITS-1:0]    thread_ff, thread_in;
   logic [ENTRY_BITS-1:0]     ridx_ff, ridx_in;
   logic [TAG_WIDTH-1:0]      page_ff, page_in;
   logic [PN_WIDTH-1:0]       pn_ff, pn_in;
   logic [SET_BITS-1:0]       set_ff, set_in;
   logic [ENTRY_BITS-1:0]     slot_ff, slot_in;
   logic [TAG_WIDTH-1:0]      tag_ff, tag_in;
   status_type                status_ff, status_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   status_type                rsp_status_ff, rsp_status_in;
   logic [ENTRY_BITS-1:0]     rsp_slot_ff, rsp_slot_in;
   logic [TAG_WIDTH-1:0]      rsp_tag_ff, rsp_tag_in;
   logic [COUNT_WIDTH-1:0]    rsp_count_ff, rsp_count_in;

   logic [PN_WIDTH-1:0]       prod;
   logic                      csr_write;

   logic                      tag_we;
   logic [SET_BITS-1:0]       tag_waddr;
   row_type                   tag_wdata;
   row_type                   tag_rdata;
   logic                      cnt_we;
   logic [CNT_ADDR_BITS-1:0]  cnt_waddr;
   logic [COUNT_WIDTH-1:0]    cnt_wdata;
   logic [CNT_ADDR_BITS-1:0]  cnt_raddr;
   logic [COUNT_WIDTH-1:0]    cnt_rdata;
   logic [COUNT_WIDTH-1:0]    cnt_next;
   match_type                 match;

   pac_ram #(.WIDTH(ROW_WIDTH), .DEPTH(SETS)) u_tag_ram (
      .clock   (clock),
      .wr_en   (tag_we),
      .wr_addr (tag_waddr),
      .wr_data (tag_wdata),
      .rd_addr (set_ff),
      .rd_data (tag_rdata)
   );

   pac_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(CNT_DEPTH)) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_waddr),
      .wr_data (cnt_wdata),
      .rd_addr (cnt_raddr),
      .rd_data (cnt_rdata)
   );

   pac_match u_match (
      .row       (tag_rdata),
      .page_base (page_ff),
      .result    (match)
   );

   assign prod      = pn_ff * HASH_MULT;
   assign cnt_raddr = {slot_in, thread_ff};
   assign csr_write = psel && penable && pwrite && pready && (paddr[2] == CSR_PAGE_SHIFT);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         shift_ff     <= SHIFT_RESET;
         clr_ff       <= '0;
         pages_ff     <= '0;
         fail_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         shift_ff     <= shift_in;
         clr_ff       <= clr_in;
         pages_ff     <= pages_in;
         fail_ff      <= fail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      thread_ff     <= thread_in;
      ridx_ff       <= ridx_in;
      page_ff       <= page_in;
      pn_ff         <= pn_in;
      set_ff        <= set_in;
      slot_ff       <= slot_in;
      tag_ff        <= tag_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_count_ff  <= rsp_count_in;
   end

   always_comb begin
      state_in      = state_ff;
      shift_in      = shift_ff;
      clr_in        = clr_ff;
      pages_in      = pages_ff;
      fail_in       = fail_ff;
      mode_in       = mode_ff;
      thread_in     = thread_ff;
      ridx_in       = ridx_ff;
      page_in       = page_ff;
      pn_in         = pn_ff;
      set_in        = set_ff;
      slot_in       = slot_ff;
      tag_in        = tag_ff;
      status_in     = status_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_count_in  = rsp_count_ff;
      tag_we        = 1'b0;
      tag_waddr     = set_ff;
      tag_wdata     = tag_rdata;
      cnt_we        = 1'b0;
      cnt_waddr     = {slot_ff, thread_ff};
      cnt_next      = cnt_rdata;
      cnt_wdata     = cnt_next;

      if (csr_write) begin
         shift_in = pwdata[SHIFT_WIDTH-1:0];
      end

      case (state_ff)
         ST_CLEAR: begin
            tag_we    = 1'b1;
            tag_waddr = clr_ff[SET_BITS-1:0];
            tag_wdata = '0;
            cnt_we    = 1'b1;
            cnt_waddr = clr_ff;
            cnt_wdata = '0;
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (start) begin
               mode_in   = req_mode;
               thread_in = THREAD_BITS'(req_thread);
               ridx_in   = ENTRY_BITS'(req_read_index);
               page_in   = req_address & ({ADDR_WIDTH{1'b1}} << shift_ff);
               pn_in     = PN_WIDTH'(req_address >> shift_ff);
               state_in  = ST_HASH;
            end
         end
         ST_HASH: begin
            if (mode_ff == MODE_READ) begin
               set_in = ridx_ff[ENTRY_BITS-1:WAY_BITS];
            end else begin
               set_in = prod[PN_WIDTH-1 -: SET_BITS];
            end
            state_in = ST_TAG;
         end
         ST_TAG: begin
            state_in = ST_MATCH;
         end
         ST_MATCH: begin
            if (mode_ff == MODE_READ) begin
               status_in = STATUS_READ;
               slot_in   = ridx_ff;
               tag_in    = tag_rdata[ridx_ff[WAY_BITS-1:0]];
            end else if (match.hit) begin
               status_in = STATUS_HIT;
               slot_in   = {set_ff, match.way};
               tag_in    = page_ff;
            end else if (match.free) begin
               // claim the first empty way of the set
               status_in            = STATUS_ALLOC;
               slot_in              = {set_ff, match.way};
               tag_in               = page_ff;
               tag_we               = 1'b1;
               tag_wdata[match.way] = page_ff;
               if (pages_ff != PAGES_MAX) begin
                  pages_in = pages_ff + 1'b1;
               end
            end else begin
               status_in = STATUS_DROP;
               slot_in   = '0;
               tag_in    = '0;
               if (fail_ff != '1) begin
                  fail_in = fail_ff + 1'b1;
               end
            end
            state_in = ST_COUNT;
         end
         ST_COUNT: begin
            case (status_ff)
               STATUS_HIT, STATUS_ALLOC: begin
                  if (cnt_rdata != '1) begin
                     cnt_next = cnt_rdata + 1'b1;
                  end
                  cnt_we    = 1'b1;
                  cnt_wdata = cnt_next;
               end
               STATUS_DROP: begin
                  cnt_next = '0;
               end
               default: begin
                  cnt_next = cnt_rdata;
               end
            endcase
            rsp_valid_in  = 1'b1;
            rsp_status_in = status_ff;
            rsp_slot_in   = slot_ff;
            rsp_tag_in    = tag_ff;
            rsp_count_in  = cnt_next;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_entry_slot   = SLOT_WIDTH'(rsp_slot_ff);
   assign rsp_page_tag     = rsp_tag_ff;
   assign rsp_access_count = RCOUNT_WIDTH'(rsp_count_ff);
   assign rsp_pages_in_use = pages_ff;
   assign rsp_fail_count   = fail_ff;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == CSR_PAGE_SHIFT) ? CSR_DATA_WIDTH'(shift_ff) : '0;

endmodule
